// ----- rtl/pats_pkg.sv -----
// shared types and constants of the period-averaged timestamp smoother
`timescale 1ns / 1ps

package pats_pkg;

   // field widths
   localparam int TIME_W   = 48;
   localparam int PERIOD_W = 24;
   localparam int CFG_W    = 16;

   // working widths of the prediction and correction paths
   localparam int PRED_W  = TIME_W + 1;
   localparam int ERR_W   = TIME_W + 2;
   localparam int LIMIT_W = PERIOD_W + CFG_W;
   localparam int FRAC_W  = 16;
   localparam int SMALL_W = PERIOD_W + 1;
   localparam int GAIN_W  = FRAC_W + 2;
   localparam int PROD_W  = SMALL_W + GAIN_W;
   localparam int CORR_W  = PROD_W - FRAC_W;

   // register reset values, Q0.16
   localparam logic [CFG_W-1:0] SMOOTHING_RESET = 16'd62259;
   localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd32768;

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SMOOTHING_FACTOR = 1'b0,
      CSR_JITTER_THRESHOLD = 1'b1
   } csr_index_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_PREDICT,
      ST_ERROR,
      ST_MULT,
      ST_FINISH
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic update;
      logic div_step;
      logic predict;
      logic error;
      logic mult;
      logic finish;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic div_last;
   } status_type;

endpackage

// ----- rtl/pats_datapath.sv -----
// datapath: period window, mean divider, prediction, correction and output register
`timescale 1ns / 1ps

module pats_datapath #(
   parameter int WINDOW = 50
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pats_pkg::cmd_type                 cmd,
   output pats_pkg::status_type              status,
   input  logic                              csr_write_enable,
   input  logic [pats_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pats_pkg::CFG_W-1:0]        csr_write_data,
   input  logic [pats_pkg::TIME_W-1:0]       req_receive_time,
   input  logic [pats_pkg::PERIOD_W-1:0]     req_period_sample,
   output logic [pats_pkg::TIME_W-1:0]       rsp_smoothed_time,
   output logic [pats_pkg::PERIOD_W-1:0]     rsp_mean_period,
   output logic                              rsp_corrected
);
   import pats_pkg::*;

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int SUM_W  = PERIOD_W + FILL_W;
   localparam int DCNT_W = $clog2(SUM_W);

   // configuration registers
   logic [CFG_W-1:0] smoothing_ff, smoothing_in;
   logic [CFG_W-1:0] threshold_ff, threshold_in;

   // captured item
   logic [TIME_W-1:0]   recv_ff;
   logic [PERIOD_W-1:0] sample_ff;

   // window state
   logic [PERIOD_W-1:0] hist_mem [WINDOW];
   logic [PERIOD_W-1:0] rd_ff;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                full;

   // divider
   logic [SUM_W-1:0]  dq_ff, dq_in;
   logic [FILL_W-1:0] rem_ff, rem_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [FILL_W:0]   trial;
   logic              trial_fits;
   logic [PERIOD_W-1:0] mean;

   // prediction and correction
   logic [TIME_W-1:0]        prev_ff, prev_in;
   logic                     have_prev_ff, have_prev_in;
   logic [PRED_W-1:0]        pred_ff;
   logic [LIMIT_W-1:0]       limit_ff;
   logic signed [ERR_W-1:0]  err_ff;
   logic [ERR_W-1:0]         mag;
   logic                     within_ff;
   logic [FRAC_W:0]          gain;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [CORR_W-1:0] corr;
   logic [TIME_W-1:0]        smoothed;
   logic                     use_corr;

   // output register
   logic [TIME_W-1:0]   out_time_ff;
   logic [PERIOD_W-1:0] out_mean_ff;
   logic                out_corr_ff;

   // configuration writes
   always_comb begin
      smoothing_in = smoothing_ff;
      threshold_in = threshold_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SMOOTHING_FACTOR: smoothing_in = csr_write_data;
            CSR_JITTER_THRESHOLD: threshold_in = csr_write_data;
            default: ;
         endcase
      end
   end

   // window bookkeeping
   always_comb begin
      full    = (fill_ff == FILL_W'(WINDOW));
      sum_in  = sum_ff - (full ? SUM_W'(rd_ff) : '0) + SUM_W'(sample_ff);
      fill_in = full ? fill_ff : fill_ff + 1'b1;
      slot_in = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
   end

   // restoring divider step, one quotient bit a cycle
   always_comb begin
      trial      = {rem_ff, dq_ff[SUM_W-1]};
      trial_fits = (trial >= {1'b0, fill_ff});
      rem_in     = trial_fits ? FILL_W'(trial - {1'b0, fill_ff}) : trial[FILL_W-1:0];
      dq_in      = {dq_ff[SUM_W-2:0], trial_fits};
      dcnt_in    = dcnt_ff + 1'b1;
      mean       = dq_ff[PERIOD_W-1:0];
      status.div_last = (dcnt_ff == DCNT_W'(SUM_W - 1));
   end

   // error magnitude, gain and final sum
   always_comb begin
      mag      = err_ff[ERR_W-1] ? ERR_W'(-err_ff) : ERR_W'(err_ff);
      gain     = {1'b1, {FRAC_W{1'b0}}} - {1'b0, smoothing_ff};
      prod_in  = $signed(err_ff[SMALL_W-1:0]) * $signed({1'b0, gain});
      corr     = prod_ff[PROD_W-1:FRAC_W];
      smoothed = pred_ff[TIME_W-1:0] + {{(TIME_W - CORR_W){corr[CORR_W-1]}}, corr};
      use_corr = have_prev_ff && (smoothing_ff != '0) && within_ff;
      prev_in  = use_corr ? smoothed : recv_ff;
      have_prev_in = 1'b1;
   end

   // control-side registers
   always_ff @(posedge clock) begin
      if (reset) begin
         smoothing_ff <= SMOOTHING_RESET;
         threshold_ff <= THRESHOLD_RESET;
         sum_ff       <= '0;
         fill_ff      <= '0;
         slot_ff      <= '0;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         dcnt_ff      <= '0;
      end else begin
         smoothing_ff <= smoothing_in;
         threshold_ff <= threshold_in;
         if (cmd.update) begin
            sum_ff  <= sum_in;
            fill_ff <= fill_in;
            slot_ff <= slot_in;
            dcnt_ff <= '0;
         end else if (cmd.div_step) begin
            dcnt_ff <= dcnt_in;
         end
         if (cmd.finish) begin
            prev_ff      <= prev_in;
            have_prev_ff <= have_prev_in;
         end
      end
   end

   // history memory, registered read of the slot about to be replaced
   always_ff @(posedge clock) begin
      rd_ff <= hist_mem[slot_ff];
      if (cmd.update) begin
         hist_mem[slot_ff] <= sample_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         recv_ff   <= req_receive_time;
         sample_ff <= req_period_sample;
      end
      if (cmd.update) begin
         dq_ff  <= sum_in;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         dq_ff  <= dq_in;
         rem_ff <= rem_in;
      end
      if (cmd.predict) begin
         pred_ff  <= {1'b0, prev_ff} + PRED_W'(mean);
         limit_ff <= mean * threshold_ff;
      end
      if (cmd.error) begin
         err_ff <= $signed({2'b00, recv_ff}) - $signed({1'b0, pred_ff});
      end
      if (cmd.mult) begin
         within_ff <= (mag[ERR_W-1:PERIOD_W] == '0)
                      && ({mag[PERIOD_W-1:0], {FRAC_W{1'b0}}} < limit_ff);
         prod_ff   <= prod_in;
      end
      if (cmd.finish) begin
         out_time_ff <= prev_in;
         out_mean_ff <= mean;
         out_corr_ff <= use_corr;
      end
   end

   assign rsp_smoothed_time = out_time_ff;
   assign rsp_mean_period   = out_mean_ff;
   assign rsp_corrected     = out_corr_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WINDOW))
      else $error("fill count beyond window");
   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_W'(WINDOW - 1))
      else $error("write slot beyond window");
   a_sum_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.update |=> $stable(sum_ff))
      else $error("period sum changed without an update");
`endif

endmodule

// ----- rtl/pats_ctrl.sv -----
// controller: sequences one item through window update, division and correction
`timescale 1ns / 1ps

module pats_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pats_pkg::status_type status,
   output pats_pkg::cmd_type    cmd
);
   import pats_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      out_free  = !rsp_valid_ff || rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            // no item taken while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.accept = 1'b1;
               state_in   = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_PREDICT;
            end
         end
         ST_PREDICT: begin
            cmd.predict = 1'b1;
            state_in    = ST_ERROR;
         end
         ST_ERROR: begin
            cmd.error = 1'b1;
            state_in  = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.finish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result shown without a finishing step");
   a_accept_updates: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == ST_UPDATE)
      else $error("accepted item not taken into the window");
   a_finish_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");
`endif

endmodule

// ----- rtl/period_averaged_timestamp_smoother.sv -----
// top level of the period-averaged timestamp smoother
//
//  channel  direction  handshake              payload
//  req      in         req_valid/req_ready    req_receive_time, req_period_sample
//  rsp      out        rsp_valid/rsp_ready    rsp_smoothed_time, rsp_mean_period,
//                                             rsp_corrected
//  csr      in         csr_write_enable       csr_index, csr_write_data
//
// one item at a time: acceptance is followed by the window update, the restoring divider for
// the window mean (one quotient bit a cycle), prediction, error, correction and result load.
// next item is accepted the cycle after the result is loaded.
// synchronous reset clears the window, the prediction and both registers to defaults.
// a stalled result holds in the output register; a further result waits behind it.
`timescale 1ns / 1ps

module period_averaged_timestamp_smoother #(
   parameter int WINDOW = 50
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pats_pkg::TIME_W-1:0]       req_receive_time,
   input  logic [pats_pkg::PERIOD_W-1:0]     req_period_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pats_pkg::TIME_W-1:0]       rsp_smoothed_time,
   output logic [pats_pkg::PERIOD_W-1:0]     rsp_mean_period,
   output logic                              rsp_corrected,
   input  logic                              csr_write_enable,
   input  logic [pats_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pats_pkg::CFG_W-1:0]        csr_write_data
);
   import pats_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing
   pats_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and storage
   pats_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_receive_time  (req_receive_time),
      .req_period_sample (req_period_sample),
      .rsp_smoothed_time (rsp_smoothed_time),
      .rsp_mean_period   (rsp_mean_period),
      .rsp_corrected     (rsp_corrected)
   );

endmodule
